FILE: rtl/mrrs_pkg.sv
// Types and constants shared by the multilevel round-robin scheduler.
package mrrs_pkg;

  localparam int ID_W    = 6;
  localparam int KIND_W  = 2;
  localparam int LVLIN_W = 3;
  localparam int SLICE_W = 8;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_RUN   = 2'd0,
    KIND_SLEEP = 2'd1,
    KIND_BLOCK = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 2'd0,
    MODE_SLEEP   = 2'd1,
    MODE_READY   = 2'd2,
    MODE_BLOCKED = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_BA, S_BB, S_SCAN, S_ADD, S_LEAVE, S_TICK, S_TWR, S_FA, S_FB, S_FC
  } state_t;

endpackage

FILE: rtl/mrrs_if.sv
// Command and result channel interfaces of the scheduler.
interface mrrs_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [mrrs_pkg::KIND_W-1:0]  kind;
  logic [mrrs_pkg::ID_W-1:0]    task_id;
  logic                         keep_level;
  logic [mrrs_pkg::LVLIN_W-1:0] new_level;
  logic [mrrs_pkg::SLICE_W-1:0] slice;
  modport source (output valid, kind, task_id, keep_level, new_level, slice, input ready);
  modport sink   (input valid, kind, task_id, keep_level, new_level, slice, output ready);
endinterface

interface mrrs_res_if;
  logic                         valid;
  logic                         ready;
  logic [mrrs_pkg::ID_W-1:0]    current_task;
  logic [mrrs_pkg::SLICE_W-1:0] current_slice;
  logic                         switched;
  logic [mrrs_pkg::STAT_W-1:0]  status;
  modport source (output valid, current_task, current_slice, switched, status, input ready);
  modport sink   (input valid, current_task, current_slice, switched, status, output ready);
endinterface

FILE: rtl/multilevel_round_robin_scheduler_unit.sv
// Top level: multilevel round-robin task scheduler with a small sequencer.
//
//   channel | dir | handshake    | payload
//   in_if   | in  | valid/ready  | kind, task_id, keep_level, new_level, slice
//   out_if  | out | valid/ready  | current_task, current_slice, switched, status
//
// One command at a time. For a removal the list RAM read port walks the task's
// level list once, shifting entries down behind the hit.
// After reset every task table entry is swept to sleep with in_if.ready low.
// A result waiting on out_if does not stop the next command being accepted; only
// the final load of a result stalls until the output register is free.
module multilevel_round_robin_scheduler_unit #(
  parameter int NUM_TASKS  = 64,
  parameter int NUM_LEVELS = 8,
  parameter int LIST_DEPTH = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  mrrs_cmd_if.sink   in_if,
  mrrs_res_if.source out_if
);
  localparam int TAW = $clog2(NUM_TASKS);
  localparam int LW  = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS) : 1;
  localparam int ALW = $clog2(NUM_LEVELS + 1);
  localparam int IW  = $clog2(LIST_DEPTH);
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int LAW = $clog2(NUM_LEVELS * LIST_DEPTH);
  localparam int TEW = mrrs_pkg::MODE_W + LW + mrrs_pkg::SLICE_W;
  localparam int IDW = mrrs_pkg::ID_W;
  localparam int SW  = mrrs_pkg::SLICE_W;

  function automatic logic [LAW-1:0] laddr(logic [LW-1:0] l, logic [IW-1:0] i);
    return LAW'(l) * LAW'(LIST_DEPTH) + LAW'(i);
  endfunction

  mrrs_pkg::state_t  state_r, state_nxt;
  mrrs_pkg::kind_t   kind_r, kind_nxt;
  mrrs_pkg::mode_t   tmode_r, tmode_nxt;
  logic [IDW-1:0]    tid_r, tid_nxt;
  logic              keep_r, keep_nxt;
  logic [mrrs_pkg::LVLIN_W-1:0] nl_r, nl_nxt;
  logic [SW-1:0]     slin_r, slin_nxt;
  logic [LW-1:0]     tlev_r, tlev_nxt, lv_r, lv_nxt;
  logic [SW-1:0]     tslice_r, tslice_nxt;
  logic              had_r, had_nxt, has_r, has_nxt, was_r, was_nxt;
  logic [IDW-1:0]    before_r, before_nxt, after_r, after_nxt;
  logic              full_r, full_nxt;
  logic [IW-1:0]     q_r, q_nxt, fi_r, fi_nxt;
  logic [CW-1:0]     nreg_r, nreg_nxt;
  logic              found_r, found_nxt;
  logic [ALW-1:0]    active_r, active_nxt;
  logic              lchg_r, lchg_nxt;
  logic [CW-1:0]     cnt_r [NUM_LEVELS];
  logic [CW-1:0]     cnt_nxt [NUM_LEVELS];
  logic [IW-1:0]     cur_r [NUM_LEVELS];
  logic [IW-1:0]     cur_nxt [NUM_LEVELS];
  logic [TAW-1:0]    clr_r, clr_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [IDW-1:0]    otask_r, otask_nxt;
  logic [SW-1:0]     oslice_r, oslice_nxt;
  logic              osw_r, osw_nxt;
  mrrs_pkg::status_t ostat_r, ostat_nxt;

  // RAM ports
  logic             l_we, t_we;
  logic [LAW-1:0]   l_waddr, l_raddr;
  logic [IDW-1:0]   l_wdata, l_rdata;
  logic [TAW-1:0]   t_waddr, t_raddr;
  logic [TEW-1:0]   t_wdata, t_rdata;

  mrrs_ram #(.WIDTH(IDW), .DEPTH(NUM_LEVELS * LIST_DEPTH)) u_list (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );
  mrrs_ram #(.WIDTH(TEW), .DEPTH(NUM_TASKS)) u_task (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );

  mrrs_pkg::mode_t rmode;
  logic [LW-1:0]   rlev;
  logic [SW-1:0]   rslc;
  assign rmode = mrrs_pkg::mode_t'(t_rdata[TEW-1 -: mrrs_pkg::MODE_W]);
  assign rlev  = t_rdata[SW +: LW];
  assign rslc  = t_rdata[SW-1:0];

  // shared level-table read port
  logic [LW-1:0] ix;
  logic [CW-1:0] cnt_ix;
  logic [IW-1:0] cur_ix;
  assign cnt_ix = cnt_r[ix];
  assign cur_ix = cur_r[ix];

  // lowest-numbered non-empty level, or NUM_LEVELS if all are empty
  logic [ALW-1:0] pick;
  always_comb begin
    pick = ALW'(NUM_LEVELS);
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        pick = ALW'(i);
      end
    end
  end

  logic in_acc;
  assign in_acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == mrrs_pkg::S_IDLE);

  always_comb begin
    logic          a_ok, hsel, tok, hit, fnow, go_off;
    logic [IW-1:0] k, fidx, c;
    logic [CW-1:0] qn, n1, kk;
    logic [LW-1:0] lv, nls;
    mrrs_pkg::state_t cont;

    state_nxt = state_r;   kind_nxt = kind_r;   tid_nxt = tid_r;   keep_nxt = keep_r;
    nl_nxt = nl_r;         slin_nxt = slin_r;   tmode_nxt = tmode_r;
    tlev_nxt = tlev_r;     lv_nxt = lv_r;       tslice_nxt = tslice_r;
    had_nxt = had_r;       has_nxt = has_r;     was_nxt = was_r;
    before_nxt = before_r; after_nxt = after_r; full_nxt = full_r;
    q_nxt = q_r;           fi_nxt = fi_r;       nreg_nxt = nreg_r;   found_nxt = found_r;
    active_nxt = active_r; lchg_nxt = lchg_r;   cnt_nxt = cnt_r;     cur_nxt = cur_r;
    clr_nxt = clr_r;
    otask_nxt = otask_r;   oslice_nxt = oslice_r; osw_nxt = osw_r;   ostat_nxt = ostat_r;
    ovalid_nxt = ovalid_r && !out_if.ready;

    l_we = 1'b0; l_waddr = '0; l_wdata = tid_r; l_raddr = '0;
    t_we = 1'b0; t_waddr = TAW'(tid_r); t_raddr = TAW'(tid_r);
    t_wdata = {tmode_r, tlev_r, tslice_r};

    ix = LW'(active_r);
    a_ok = 32'(active_r) < NUM_LEVELS;
    hsel = 1'b0; tok = 1'b0; hit = 1'b0; fnow = 1'b0; go_off = 1'b0;
    k = '0; fidx = '0; c = '0; qn = '0; n1 = '0; kk = '0; lv = '0; nls = '0;
    cont = (kind_r == mrrs_pkg::KIND_RUN) ? mrrs_pkg::S_ADD : mrrs_pkg::S_LEAVE;

    unique case (state_r)
      mrrs_pkg::S_CLR: begin
        t_we = 1'b1;
        t_waddr = clr_r;
        t_wdata = {mrrs_pkg::MODE_SLEEP, {LW{1'b0}}, {SW{1'b0}}};
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == NUM_TASKS - 1) begin
          state_nxt = mrrs_pkg::S_IDLE;
        end
      end
      mrrs_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_nxt = mrrs_pkg::kind_t'(in_if.kind);
          tid_nxt  = in_if.task_id;
          keep_nxt = in_if.keep_level;
          nl_nxt   = in_if.new_level;
          slin_nxt = in_if.slice;
          full_nxt = 1'b0;
          was_nxt  = 1'b0;
          state_nxt = mrrs_pkg::S_BA;
        end
      end
      mrrs_pkg::S_BA, mrrs_pkg::S_FA: begin
        hsel = a_ok && (cnt_ix != '0);
        k = (CW'(cur_ix) >= cnt_ix) ? '0 : cur_ix;
        l_raddr = laddr(ix, k);
        if (state_r == mrrs_pkg::S_BA) begin
          had_nxt = hsel;
          state_nxt = mrrs_pkg::S_BB;
        end else begin
          has_nxt = hsel;
          state_nxt = mrrs_pkg::S_FB;
        end
      end
      mrrs_pkg::S_BB: begin
        before_nxt = l_rdata;
        tmode_nxt  = rmode;
        tlev_nxt   = rlev;
        tslice_nxt = rslc;
        tok = 32'(tid_r) < NUM_TASKS;
        ix = rlev;
        nls = (32'(nl_r) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(nl_r);
        lv = keep_r ? rlev : nls;
        unique case (kind_r)
          mrrs_pkg::KIND_TICK: state_nxt = mrrs_pkg::S_TICK;
          mrrs_pkg::KIND_RUN: begin
            lv_nxt = lv;
            if (slin_r != '0) begin
              tslice_nxt = slin_r;
            end
            if (!tok) begin
              state_nxt = mrrs_pkg::S_FA;
            end else if (rmode == mrrs_pkg::MODE_READY && rlev != lv) begin
              go_off = 1'b1;
            end else begin
              state_nxt = mrrs_pkg::S_ADD;
            end
          end
          default: begin
            if (tok && rmode == mrrs_pkg::MODE_READY) begin
              was_nxt = had_r && (l_rdata == tid_r);
              go_off = 1'b1;
            end else begin
              state_nxt = mrrs_pkg::S_FA;
            end
          end
        endcase
        if (go_off) begin
          // start the list walk on the task's own level
          tmode_nxt = mrrs_pkg::MODE_SLEEP;
          nreg_nxt  = cnt_ix;
          q_nxt     = '0;
          found_nxt = 1'b0;
          l_raddr   = laddr(rlev, '0);
          state_nxt = (cnt_ix == '0) ? cont : mrrs_pkg::S_SCAN;
        end
      end
      mrrs_pkg::S_SCAN: begin
        ix = tlev_r;
        hit = (l_rdata == tid_r);
        fnow = found_r || hit;
        fidx = found_r ? fi_r : q_r;
        found_nxt = fnow;
        fi_nxt = fidx;
        if (found_r) begin
          // shift the entry down over the removed one
          l_we = 1'b1;
          l_waddr = laddr(tlev_r, q_r - 1'b1);
          l_wdata = l_rdata;
        end
        qn = CW'(q_r) + 1'b1;
        if (qn < nreg_r) begin
          q_nxt = IW'(qn);
          l_raddr = laddr(tlev_r, IW'(qn));
        end else begin
          if (fnow) begin
            n1 = nreg_r - 1'b1;
            cnt_nxt[ix] = n1;
            c = cur_ix;
            if (fidx < c) begin
              c = c - 1'b1;
            end
            if (CW'(c) >= n1) begin
              c = '0;
            end
            cur_nxt[ix] = c;
          end
          state_nxt = cont;
        end
      end
      mrrs_pkg::S_ADD: begin
        ix = lv_r;
        if (tmode_r != mrrs_pkg::MODE_READY) begin
          if (32'(cnt_ix) >= LIST_DEPTH) begin
            full_nxt = 1'b1;
          end else begin
            l_we = 1'b1;
            l_waddr = laddr(lv_r, IW'(cnt_ix));
            l_wdata = tid_r;
            cnt_nxt[ix] = cnt_ix + 1'b1;
            tmode_nxt = mrrs_pkg::MODE_READY;
            tlev_nxt = lv_r;
          end
        end
        lchg_nxt = 1'b1;
        state_nxt = mrrs_pkg::S_TWR;
      end
      mrrs_pkg::S_LEAVE: begin
        tmode_nxt = (kind_r == mrrs_pkg::KIND_SLEEP) ? mrrs_pkg::MODE_SLEEP
                                                     : mrrs_pkg::MODE_BLOCKED;
        if (was_r) begin
          active_nxt = pick;
          lchg_nxt = 1'b0;
        end
        state_nxt = mrrs_pkg::S_TWR;
      end
      mrrs_pkg::S_TWR: begin
        t_we = 1'b1;
        state_nxt = mrrs_pkg::S_FA;
      end
      mrrs_pkg::S_TICK: begin
        if (a_ok) begin
          kk = CW'(cur_ix) + 1'b1;
          if (kk >= cnt_ix) begin
            kk = '0;
          end
          cur_nxt[ix] = IW'(kk);
        end
        if (lchg_r) begin
          active_nxt = pick;
          lchg_nxt = 1'b0;
        end
        state_nxt = mrrs_pkg::S_FA;
      end
      mrrs_pkg::S_FB: begin
        after_nxt = l_rdata;
        t_raddr = TAW'(l_rdata);
        state_nxt = mrrs_pkg::S_FC;
      end
      mrrs_pkg::S_FC: begin
        t_raddr = TAW'(after_r);
        if (!ovalid_r || out_if.ready) begin
          ovalid_nxt = 1'b1;
          otask_nxt  = has_r ? after_r : '0;
          oslice_nxt = has_r ? rslc : '0;
          osw_nxt    = (had_r != has_r) || (has_r && before_r != after_r);
          ostat_nxt  = full_r ? mrrs_pkg::STAT_FULL
                     : (!has_r ? mrrs_pkg::STAT_NONE : mrrs_pkg::STAT_OK);
          state_nxt  = mrrs_pkg::S_IDLE;
        end
      end
      default: state_nxt = mrrs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mrrs_pkg::S_CLR;
      clr_r    <= '0;
      active_r <= '0;
      lchg_r   <= 1'b0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i] <= '0;
        cur_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      active_r <= active_nxt;
      lchg_r   <= lchg_nxt;
      ovalid_r <= ovalid_nxt;
      cnt_r    <= cnt_nxt;
      cur_r    <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;     tid_r <= tid_nxt;       keep_r <= keep_nxt;
    nl_r <= nl_nxt;         slin_r <= slin_nxt;     tmode_r <= tmode_nxt;
    tlev_r <= tlev_nxt;     lv_r <= lv_nxt;         tslice_r <= tslice_nxt;
    had_r <= had_nxt;       has_r <= has_nxt;       was_r <= was_nxt;
    before_r <= before_nxt; after_r <= after_nxt;   full_r <= full_nxt;
    q_r <= q_nxt;           fi_r <= fi_nxt;         nreg_r <= nreg_nxt;
    found_r <= found_nxt;
    otask_r <= otask_nxt;   oslice_r <= oslice_nxt; osw_r <= osw_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_if.valid         = ovalid_r;
  assign out_if.current_task  = otask_r;
  assign out_if.current_slice = oslice_r;
  assign out_if.switched      = osw_r;
  assign out_if.status        = ostat_r;

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready)
    else $error("command accepted while busy");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(active_r) <= NUM_LEVELS)
    else $error("active level out of range");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ostat_r == mrrs_pkg::STAT_NONE) |-> (otask_r == '0 && oslice_r == '0))
    else $error("no ready task but a task reported");

  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (ostat_r == mrrs_pkg::STAT_OK || ostat_r == mrrs_pkg::STAT_FULL ||
                  ostat_r == mrrs_pkg::STAT_NONE))
    else $error("undefined status code");

endmodule

FILE: rtl/mrrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
